// ===== design/msam_pkg.sv =====
// Shared types and constants for the stream audio mixer.
// No dependencies; every other file in design/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package msam_pkg;

  localparam int MAX_STREAMS   = 8;
  localparam int STORE_SAMPLES = 131072;
  localparam int STORE_AW      = $clog2(STORE_SAMPLES);
  localparam int OFF_W         = STORE_AW + 1;
  localparam int LIM_W         = 4;
  localparam int CAP_W         = 18;
  localparam int IDX_W         = 3;
  localparam int SMP_W         = 16;
  localparam int WORD_W        = 24;
  localparam int QUEUE_DEPTH   = 4;
  localparam int Q_AW          = $clog2(QUEUE_DEPTH);

  localparam logic [LIM_W-1:0] LIMIT_RESET    = LIM_W'(1);
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(131072);

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  // Configuration register indexes
  localparam logic CFG_LIMIT    = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    REQ_MIX  = 2'd0,
    REQ_GAP  = 2'd1,
    REQ_PULL = 2'd2,
    REQ_RSVD = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOREADY = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MIX  = 2'd1,
    OP_PULL = 2'd2
  } op_t;

  // One classified word handed from the front to the back
  typedef struct packed {
    op_t                      op;
    logic [STORE_AW-1:0]      addr;
    logic signed [SMP_W-1:0]  sample;
    status_t                  status;
  } job_t;

  // One result word
  typedef struct packed {
    status_t                  status;
    logic                     smp_valid;
    logic signed [SMP_W-1:0]  sample;
  } result_t;

endpackage

`default_nettype wire

// ===== design/msam_front.sv =====
// Front end: accepts request words, tracks stream offsets and read point,
// and classifies each word into a store job. Depends on msam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msam_front
  import msam_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire req_t                    req,
  input  wire logic [IDX_W-1:0]        idx,
  input  wire logic signed [SMP_W-1:0] sample,
  input  wire logic [LIM_W-1:0]        limit_cfg,
  input  wire logic [CAP_W-1:0]        cap_cfg,
  input  wire logic                    q_full,
  input  wire logic                    back_busy,
  output logic                         push,
  output job_t                         job
);

  logic [OFF_W-1:0]       off_r   [MAX_STREAMS];
  logic [OFF_W-1:0]       off_nxt [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] started_r, started_nxt;
  logic [STORE_AW-1:0]    rp_r, rp_nxt;

  logic [LIM_W-1:0]       lim;
  logic [OFF_W-1:0]       cap_eff;
  logic [MAX_STREAMS-1:0] act, off_zero;
  logic                   idx_act, any_live, zero_live;

  assign in_tready = !q_full && !back_busy;
  assign push      = in_tvalid && in_tready;

  assign lim     = (limit_cfg > LIM_W'(MAX_STREAMS)) ? LIM_W'(MAX_STREAMS) : limit_cfg;
  assign cap_eff = (cap_cfg > CAP_W'(STORE_SAMPLES)) ? OFF_W'(STORE_SAMPLES)
                                                     : OFF_W'(cap_cfg);
  assign idx_act = LIM_W'(idx) < lim;

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      act[i]      = LIM_W'(i) < lim;
      off_zero[i] = off_r[i] == '0;
    end
  end

  assign any_live  = |(started_r & act);
  assign zero_live = |(started_r & act & off_zero);

  always_comb begin
    job.op      = OP_NONE;
    job.addr    = rp_r + off_r[idx][STORE_AW-1:0];
    job.sample  = sample;
    job.status  = ST_DONE;
    off_nxt     = off_r;
    started_nxt = started_r;
    rp_nxt      = rp_r;
    unique case (req)
      REQ_MIX, REQ_GAP: begin
        if (!idx_act) begin
          job.status = ST_UNUSED;
        end else begin
          started_nxt[idx] = 1'b1;
          if (off_r[idx] >= cap_eff) begin
            job.status = ST_FULL;
          end else begin
            if (req == REQ_MIX) begin
              job.op = OP_MIX;
            end
            off_nxt[idx] = off_r[idx] + 1'b1;
          end
        end
      end
      REQ_PULL: begin
        if (!any_live || zero_live) begin
          job.status = ST_NOREADY;
        end else begin
          job.op   = OP_PULL;
          job.addr = rp_r;
          rp_nxt   = rp_r + 1'b1;
          for (int i = 0; i < MAX_STREAMS; i++) begin
            if (started_r[i] && act[i]) begin
              off_nxt[i] = off_r[i] - 1'b1;
            end
          end
        end
      end
      REQ_RSVD: begin
        job.status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STREAMS; i++) begin
        off_r[i] <= '0;
      end
      started_r <= '0;
      rp_r      <= '0;
    end else if (push) begin
      off_r     <= off_nxt;
      started_r <= started_nxt;
      rp_r      <= rp_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/msam_queue.sv =====
// Short job queue between the front and the back.
// Depends on msam_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module msam_queue
  import msam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      q_valid,
  output logic      q_full
);

  job_t            q_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign head    = q_r[rd_ptr_r];
  assign q_valid = count_r != '0;
  assign q_full  = count_r == (Q_AW + 1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/msam_back.sv =====
// Back end: owns the mix store, runs the clearing pass after reset, does the
// read-modify-write for each store job and holds the result register. Uses msam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msam_back
  import msam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t head,
  output logic      pop,
  output logic      busy,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output result_t   res
);

  typedef enum logic [1:0] {S_CLEAR, S_RUN, S_WRITE} state_t;

  logic [SMP_W-1:0]    mix_store_r [STORE_SAMPLES];
  logic [SMP_W-1:0]    rd_r;

  state_t              state_r;
  logic [STORE_AW-1:0] clr_addr_r;
  job_t                cur_r;
  logic                out_valid_r;
  result_t             res_r;

  logic                out_free;
  logic                res_load;
  logic                mem_we, mem_re;
  logic [STORE_AW-1:0] mem_addr;
  logic [SMP_W-1:0]    mem_wdata;

  // Soft clip: both negative adds ab/32768, both positive subtracts ab/32767
  // (quotient by 32767 from a shift plus a one-step correction).
  function automatic logic [SMP_W-1:0] soft_mix(input logic signed [SMP_W-1:0] a,
                                                input logic signed [SMP_W-1:0] b);
    logic signed [31:0] ae, be, p, r;
    logic [16:0]        t, rem, q;
    ae  = 32'(a);
    be  = 32'(b);
    p   = ae * be;
    t   = p[31:15];
    rem = {2'b00, p[14:0]} + t;
    q   = (rem >= 17'(SMP_MAX)) ? t + 1'b1 : t;
    if (a < 0 && b < 0) begin
      r = ae + be + 32'(t);
    end else if (a > 0 && b > 0) begin
      r = ae + be - 32'(q);
    end else begin
      r = ae + be;
    end
    return r[SMP_W-1:0];
  endfunction

  assign out_free   = !out_valid_r || out_tready;
  assign busy       = state_r == S_CLEAR;
  assign out_tvalid = out_valid_r;
  assign res        = res_r;

  always_comb begin
    pop       = 1'b0;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = head.addr;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr_r;
      end
      S_RUN: begin
        pop = q_valid && (head.op != OP_NONE || out_free);
        if (pop && head.op != OP_NONE) begin
          mem_re = 1'b1;
        end
        res_load = pop && head.op == OP_NONE;
      end
      S_WRITE: begin
        mem_addr = cur_r.addr;
        res_load = out_free;
        if (out_free) begin
          mem_we    = 1'b1;
          mem_wdata = (cur_r.op == OP_MIX) ? soft_mix(rd_r, cur_r.sample) : '0;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mix_store_r[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_r <= mix_store_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (pop) begin
            if (head.op == OP_NONE) begin
              res_r.status    <= head.status;
              res_r.smp_valid <= 1'b0;
              res_r.sample    <= '0;
            end else begin
              cur_r   <= head;
              state_r <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            res_r.status    <= cur_r.status;
            res_r.smp_valid <= cur_r.op == OP_PULL;
            res_r.sample    <= (cur_r.op == OP_PULL) ? rd_r : '0;
            state_r         <= S_RUN;
          end
        end
        default: begin
          state_r <= S_RUN;
        end
      endcase
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !pop)
    else $error("job taken during clearing pass");

  a_store_job_goes_to_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && pop && head.op != OP_NONE) |=> state_r == S_WRITE)
    else $error("store job did not reach write phase");

  a_sample_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.smp_valid) |-> res_r.sample == '0)
    else $error("sample not zero on a result without sample");

  a_sample_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.smp_valid) |-> res_r.status == ST_DONE)
    else $error("emitted sample with non-done status");

endmodule

`default_nettype wire

// ===== design/multi_stream_aligned_audio_mixer.sv =====
// Top level of the multi-stream soft-clip audio mixer: configuration registers,
// word packing and the front / queue / back split. Depends on msam_pkg and all msam_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Up to eight streams mix signed 16-bit samples into a 131072-entry ring store,
// each stream writing at its own offset from the read point. A mix or gap word
// is classified at once by the front end, which holds the offsets, started
// flags and read point; store work then runs in the back end behind a
// four-word queue, so the input keeps taking words while results wait.
// Every input word gives exactly one result word, in order. A mix or pull is
// read in S_RUN and written back to the single-port store in S_WRITE, which
// waits for a free result register; the back end takes no new job until that
// write is done. Gaps, rejected words and status-only pulls need no store access.
// After reset the back end clears the whole store, one entry a cycle; in_tready
// stays low until that pass ends, while configuration writes are taken as
// usual. Write configuration only while the block is idle.
module multi_stream_aligned_audio_mixer
  import msam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [WORD_W-1:0] in_tdata,   // [1:0] req_type, [4:2] stream_index,
                                             // [20:5] in_sample, [23:21] zero
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [WORD_W-1:0]      out_tdata,  // [1:0] status, [2] out_valid,
                                             // [18:3] out_sample, [23:19] zero
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [CAP_W-1:0]  cfg_wdata
);

  logic [LIM_W-1:0] limit_r;
  logic [CAP_W-1:0] cap_r;

  logic    push, pop, q_valid, q_full, back_busy;
  job_t    push_job, head;
  result_t res;

  // Configuration: take the write at once, keep only the register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      cap_r   <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LIMIT:    limit_r <= cfg_wdata[LIM_W-1:0];
        CFG_CAPACITY: cap_r   <= cfg_wdata;
      endcase
    end
  end

  // Front: accept and classify, advance offsets
  msam_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req       (req_t'(in_tdata[1:0])),
    .idx       (in_tdata[4:2]),
    .sample    (in_tdata[20:5]),
    .limit_cfg (limit_r),
    .cap_cfg   (cap_r),
    .q_full    (q_full),
    .back_busy (back_busy),
    .push      (push),
    .job       (push_job)
  );

  // Queue: let the front run ahead of the store
  msam_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  // Back: store read-modify-write and result register
  msam_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  // Pack the result word, lowest field first
  assign out_tdata = {5'b0, res.sample, res.smp_valid, res.status};

endmodule

`default_nettype wire
